>>> rtl/swc_pkg.sv
// Package for the sliding window correlation block.
// Holds default sizes, register reset value and state machine types.
// No dependencies.
`default_nettype none

package swc_pkg;

  localparam int MAX_WINDOW_DEF    = 64;
  localparam int SAMPLE_BITS_DEF   = 16;
  localparam int OUT_FRAC_BITS_DEF = 15;

  localparam int         CFG_W     = 7;
  localparam logic [6:0] WIN_RESET = 7'd30;

  typedef enum logic [2:0] {
    T_IDLE,
    T_READ,
    T_UPD,
    T_CALC,
    T_OUT
  } swc_top_state_e;

  typedef enum logic [2:0] {
    E_IDLE,
    E_PROD,
    E_SETUP,
    E_MUL,
    E_RSETUP,
    E_ROOT_A,
    E_ROOT_B,
    E_DONE
  } swc_eng_state_e;

  typedef struct packed {
    logic done;
    logic degen;
  } swc_eng_sts_t;

endpackage

`default_nettype wire

>>> rtl/swc_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none

module swc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]              rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

>>> rtl/swc_eng.sv
// Correlation engine: variance and covariance terms, shift-add products,
// then a bit-by-bit root of c^2 * 2^(2F) / (vx * vy). Uses swc_pkg.
`default_nettype none

module swc_eng import swc_pkg::*; #(
  parameter int MAX_WINDOW    = MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
  parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF,
  localparam int LW  = $clog2(MAX_WINDOW + 1),
  localparam int S1W = SAMPLE_BITS + LW,
  localparam int S2W = 2 * SAMPLE_BITS + LW
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic [LW-1:0]          len_i,
  input  wire logic signed [S1W-1:0]  sx_i,
  input  wire logic signed [S1W-1:0]  sy_i,
  input  wire logic signed [S2W-1:0]  sxx_i,
  input  wire logic signed [S2W-1:0]  syy_i,
  input  wire logic signed [S2W-1:0]  sxy_i,
  output swc_eng_sts_t                sts_o,
  output logic [OUT_FRAC_BITS:0]      corr_o
);

  localparam int F   = OUT_FRAC_BITS;
  localparam int PW  = S2W + S1W;
  localparam int VW  = 2 * SAMPLE_BITS + 2 * LW - 1;
  localparam int MW  = 2 * VW;
  localparam int TW  = MW + 2 * F;
  localparam int CW  = $clog2(VW + 1);

  swc_eng_state_e state_q, state_d;

  logic [2:0]             k_q;
  logic [CW-1:0]          cnt_q;
  logic signed [S2W-1:0]  mul_a;
  logic signed [S1W-1:0]  mul_b;
  logic signed [PW-1:0]   prod_q, hold_q, diff;
  logic [2:0]             kp;
  logic [VW-1:0]          vx_q, vy_q, cmag_q;
  logic                   cneg_q, degen_q;
  logic [MW-1:0]          acc_p_q, acc_c_q, mc_p_q, mc_c_q;
  logic [VW-1:0]          ml_p_q, ml_c_q;
  logic [TW-1:0]          t_q, ush_q, p2b_q, rr_q, tmp_q, cand;
  logic                   take;
  logic [F-1:0]           r_q, mask_q;

  always_comb begin
    mul_a = sxx_i;
    mul_b = $signed({{(S1W-LW){1'b0}}, len_i});
    case (k_q)
      3'd0: begin mul_a = sxx_i;       mul_b = $signed({{(S1W-LW){1'b0}}, len_i}); end
      3'd1: begin mul_a = S2W'(sx_i);  mul_b = sx_i; end
      3'd2: begin mul_a = syy_i;       mul_b = $signed({{(S1W-LW){1'b0}}, len_i}); end
      3'd3: begin mul_a = S2W'(sy_i);  mul_b = sy_i; end
      3'd4: begin mul_a = sxy_i;       mul_b = $signed({{(S1W-LW){1'b0}}, len_i}); end
      3'd5: begin mul_a = S2W'(sx_i);  mul_b = sy_i; end
      default: begin mul_a = '0;       mul_b = '0; end
    endcase
  end

  assign kp   = k_q - 3'd1;
  assign diff = hold_q - prod_q;
  assign cand = tmp_q + p2b_q;
  assign take = (cand <= rr_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      E_IDLE:   if (start_i) state_d = E_PROD;
      E_PROD:   if (k_q == 3'd6) state_d = E_SETUP;
      E_SETUP:  state_d = ((vx_q == '0) || (vy_q == '0)) ? E_DONE : E_MUL;
      E_MUL:    if (cnt_q == CW'(VW - 1)) state_d = E_RSETUP;
      E_RSETUP: state_d = E_ROOT_A;
      E_ROOT_A: state_d = E_ROOT_B;
      E_ROOT_B: state_d = mask_q[0] ? E_DONE : E_ROOT_A;
      E_DONE:   state_d = E_IDLE;
      default:  state_d = E_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    sts_o.done  = (state_q == E_DONE);
    sts_o.degen = degen_q;
    if (degen_q) begin
      corr_o = '0;
    end else if (cneg_q) begin
      corr_o = (F+1)'(0) - {1'b0, r_q};
    end else begin
      corr_o = {1'b0, r_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= E_IDLE;
      k_q     <= '0;
      cnt_q   <= '0;
      degen_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == E_IDLE) begin
        k_q <= '0;
      end else if (state_q == E_PROD) begin
        k_q <= k_q + 3'd1;
      end
      if (state_q == E_SETUP) begin
        degen_q <= (vx_q == '0) || (vy_q == '0);
        cnt_q   <= '0;
      end else if (state_q == E_MUL) begin
        cnt_q <= cnt_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      E_PROD: begin
        prod_q <= PW'(mul_a) * PW'(mul_b);
        if (k_q != 3'd0) begin
          if (!kp[0]) begin
            hold_q <= prod_q;
          end else begin
            case (kp[2:1])
              2'd0: vx_q <= VW'(diff);
              2'd1: vy_q <= VW'(diff);
              default: begin
                cneg_q <= diff[PW-1];
                cmag_q <= VW'(diff[PW-1] ? -diff : diff);
              end
            endcase
          end
        end
      end
      E_SETUP: begin
        acc_p_q <= '0;
        acc_c_q <= '0;
        mc_p_q  <= MW'(vx_q);
        ml_p_q  <= vy_q;
        mc_c_q  <= MW'(cmag_q);
        ml_c_q  <= cmag_q;
        r_q     <= '0;
      end
      E_MUL: begin
        if (ml_p_q[0]) acc_p_q <= acc_p_q + mc_p_q;
        if (ml_c_q[0]) acc_c_q <= acc_c_q + mc_c_q;
        mc_p_q <= mc_p_q << 1;
        mc_c_q <= mc_c_q << 1;
        ml_p_q <= ml_p_q >> 1;
        ml_c_q <= ml_c_q >> 1;
      end
      E_RSETUP: begin
        t_q    <= '0;
        ush_q  <= '0;
        p2b_q  <= TW'(acc_p_q) << (2 * F - 2);
        rr_q   <= TW'(acc_c_q) << (2 * F);
        r_q    <= '0;
        mask_q <= {1'b1, {(F-1){1'b0}}};
      end
      E_ROOT_A: begin
        tmp_q <= t_q + ush_q;
      end
      E_ROOT_B: begin
        // t = r^2 * P, ush = r * P << (b+1), p2b = P << 2b
        if (take) begin
          t_q <= cand;
          r_q <= r_q | mask_q;
        end
        ush_q  <= (ush_q >> 1) + (take ? p2b_q : '0);
        p2b_q  <= p2b_q >> 2;
        mask_q <= mask_q >> 1;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/sliding_window_correlation.sv
// Top level of the sliding window correlation block: sample ring in RAM,
// running sums, correlation engine and output register. Uses swc_pkg,
// swc_ram and swc_eng.
//
//   channel   signals                                   handshake
//   input     sample_x_i, sample_y_i, restart_i         in_valid_i / in_stall_o
//   output    corr_o, valid_res_o, degenerate_o         out_valid_o / out_stall_i
//   config    cfg_data_i (window_length)                cfg_valid_i / cfg_ready_o
//
// One item at a time. Ring read, then sum update, then the result is loaded while the
// window fills. With a full window the correlation engine runs after the sum update:
// a shift-add multiplier over VW = 2*SAMPLE_BITS + 2*clog2(MAX_WINDOW+1) - 1 bit
// operands, then the root loop. The input stalls until the result is loaded, also
// through any output stall. Reset empties the window; the ring needs no clearing.
// A stalled output holds one result while the next item is taken in.
`default_nettype none

module sliding_window_correlation import swc_pkg::*; #(
  parameter int MAX_WINDOW    = MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
  parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_x_i,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_y_i,
  input  wire logic                          restart_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic signed [OUT_FRAC_BITS:0]      corr_o,
  output logic                               valid_res_o,
  output logic                               degenerate_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [CFG_W-1:0]              cfg_data_i
);

  localparam int SB   = SAMPLE_BITS;
  localparam int LW   = $clog2(MAX_WINDOW + 1);
  localparam int AW   = $clog2(MAX_WINDOW);
  localparam int S1W  = SB + LW;
  localparam int S2W  = 2 * SB + LW;
  localparam int LENW = (LW > CFG_W) ? LW : CFG_W;

  swc_top_state_e state_q, state_d;

  logic [CFG_W-1:0]       win_q;
  logic [AW-1:0]          wp_q;
  logic [LW-1:0]          fill_q;
  logic signed [S1W-1:0]  sx_q, sy_q;
  logic signed [S2W-1:0]  sxx_q, syy_q, sxy_q;
  logic signed [SB-1:0]   x_q, y_q;
  logic signed [2*SB-1:0] xx_q, yy_q, xy_q;
  logic signed [2*SB-1:0] oxx, oyy, oxy;
  logic signed [SB-1:0]   ox, oy;

  logic [LENW-1:0] cfg_ext, len_ext;
  logic [LW-1:0]   len;
  logic [LW:0]     wpe, old_full;
  logic [AW-1:0]   raddr;
  logic            full, now_full;
  logic            accept, cfg_we, load;
  logic            eng_start;
  logic [2*SB-1:0] rdata;

  swc_eng_sts_t            eng_sts;
  logic [OUT_FRAC_BITS:0]  eng_corr;

  logic [OUT_FRAC_BITS:0]  res_corr_q;
  logic                    res_valid_q, res_degen_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i;
  assign accept      = in_valid_i && !in_stall_o;

  always_comb begin
    cfg_ext = LENW'(win_q);
    if (cfg_ext < LENW'(2)) begin
      len_ext = LENW'(2);
    end else if (cfg_ext > LENW'(MAX_WINDOW)) begin
      len_ext = LENW'(MAX_WINDOW);
    end else begin
      len_ext = cfg_ext;
    end
    len = LW'(len_ext);
  end

  assign wpe      = (LW+1)'(wp_q);
  assign old_full = (wpe >= (LW+1)'(len)) ? wpe - (LW+1)'(len)
                                          : wpe + (LW+1)'(MAX_WINDOW) - (LW+1)'(len);
  assign raddr    = old_full[AW-1:0];
  assign full     = (fill_q >= len);
  assign now_full = full || ((fill_q + LW'(1)) >= len);

  assign ox  = rdata[2*SB-1:SB];
  assign oy  = rdata[SB-1:0];
  assign oxx = ox * ox;
  assign oyy = oy * oy;
  assign oxy = ox * oy;

  swc_ram #(
    .WIDTH (2 * SB),
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (state_q == T_UPD),
    .waddr_i (wp_q),
    .wdata_i ({x_q, y_q}),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  swc_eng #(
    .MAX_WINDOW    (MAX_WINDOW),
    .SAMPLE_BITS   (SAMPLE_BITS),
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_eng (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (eng_start),
    .len_i   (len),
    .sx_i    (sx_q),
    .sy_i    (sy_q),
    .sxx_i   (sxx_q),
    .syy_i   (syy_q),
    .sxy_i   (sxy_q),
    .sts_o   (eng_sts),
    .corr_o  (eng_corr)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      T_IDLE: if (accept) state_d = T_READ;
      T_READ: state_d = T_UPD;
      T_UPD:  state_d = now_full ? T_CALC : T_OUT;
      T_CALC: if (eng_sts.done) state_d = T_OUT;
      T_OUT:  if (load) state_d = T_IDLE;
      default: state_d = T_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall_o = (state_q != T_IDLE);
    eng_start  = (state_q == T_UPD) && now_full;
    load       = (state_q == T_OUT) && (!out_valid_o || !out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      win_q       <= WIN_RESET;
      wp_q        <= '0;
      fill_q      <= '0;
      sx_q        <= '0;
      sy_q        <= '0;
      sxx_q       <= '0;
      syy_q       <= '0;
      sxy_q       <= '0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we) begin
        win_q <= cfg_data_i;
      end
      if (cfg_we || (accept && restart_i)) begin
        wp_q   <= '0;
        fill_q <= '0;
        sx_q   <= '0;
        sy_q   <= '0;
        sxx_q  <= '0;
        syy_q  <= '0;
        sxy_q  <= '0;
      end else if (state_q == T_UPD) begin
        wp_q  <= (wp_q == AW'(MAX_WINDOW - 1)) ? '0 : wp_q + AW'(1);
        if (!full) begin
          fill_q <= fill_q + LW'(1);
        end
        sx_q  <= sx_q + S1W'(x_q) - (full ? S1W'(ox) : S1W'(0));
        sy_q  <= sy_q + S1W'(y_q) - (full ? S1W'(oy) : S1W'(0));
        sxx_q <= sxx_q + S2W'(xx_q) - (full ? S2W'(oxx) : S2W'(0));
        syy_q <= syy_q + S2W'(yy_q) - (full ? S2W'(oyy) : S2W'(0));
        sxy_q <= sxy_q + S2W'(xy_q) - (full ? S2W'(oxy) : S2W'(0));
      end
      if (load) begin
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q <= sample_x_i;
      y_q <= sample_y_i;
    end
    if (state_q == T_READ) begin
      xx_q <= x_q * x_q;
      yy_q <= y_q * y_q;
      xy_q <= x_q * y_q;
    end
    if ((state_q == T_UPD) && !now_full) begin
      res_corr_q  <= '0;
      res_valid_q <= 1'b0;
      res_degen_q <= 1'b0;
    end else if ((state_q == T_CALC) && eng_sts.done) begin
      res_corr_q  <= eng_corr;
      res_valid_q <= 1'b1;
      res_degen_q <= eng_sts.degen;
    end
    if (load) begin
      corr_o       <= $signed(res_corr_q);
      valid_res_o  <= res_valid_q;
      degenerate_o <= res_degen_q;
    end
  end

endmodule

`default_nettype wire
